/* rtl/mjdc_pkg.sv */
// ----------------------------------------------------------------------------
// mjdc_pkg
// Shared types, constants and tables for the MJD to calendar date converter.
// ----------------------------------------------------------------------------
package mjdc_pkg;

    // Number of register stages from input to output
    localparam int NSTAGE = 9;

    // Julian Day offset and the first Gregorian Julian Day
    localparam logic signed [23:0] JD_OFFSET   = 24'sd2400001;
    localparam logic signed [23:0] JD_GREG     = 24'sd2299161;

    // alpha = floor((4*z - 7468865) / 146097), reciprocal scaled by 2^25
    localparam logic [25:0] ALPHA_BIAS  = 26'd7468865;
    localparam logic [24:0] ALPHA_DIV   = 25'd146097;
    localparam logic [7:0]  ALPHA_RECIP = 8'd229;

    // c = floor((20*b - 2442) / 7305); offset by 4909 divisors to stay positive,
    // reciprocal scaled by 2^28
    localparam logic signed [29:0] C_BIAS  = 30'sd35857803;
    localparam logic [27:0]        C_DIV   = 28'd7305;
    localparam logic [15:0]        C_RECIP = 16'd36746;
    localparam logic [15:0]        C_SHIFT = 16'd4909;

    localparam logic signed [15:0] YEAR_OFS_LATE  = 16'sd4716;
    localparam logic signed [15:0] YEAR_OFS_EARLY = 16'sd4715;

    // Time of day: one day less one millisecond, and the unit divisors
    localparam logic [26:0] MS_DAY_MAX = 27'd86399999;
    localparam logic [26:0] MS_HOUR    = 27'd3600000;
    localparam logic [5:0]  HOUR_RECIP = 6'd37;
    localparam logic [21:0] MS_MINUTE  = 22'd60000;
    localparam logic [6:0]  MIN_RECIP  = 7'd69;
    localparam logic [15:0] MS_SECOND  = 16'd1000;
    localparam logic [6:0]  SEC_RECIP  = 7'd65;

    typedef struct packed {
        logic [9:0] millisecond;
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
    } tod_t;

    typedef struct packed {
        logic [4:0]  day_of_month;
        logic [3:0]  month;
        logic [14:0] year;
    } date_t;

    // floor(30.6001 * e): days before month index e in the shifted year
    function automatic logic [8:0] month_start(input logic [3:0] e);
        logic [8:0] v;
        case (e)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd30;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd91;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd183;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd244;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd336;
            4'd12:   v = 9'd367;
            4'd13:   v = 9'd397;
            4'd14:   v = 9'd428;
            4'd15:   v = 9'd459;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/mjdc_date.sv */
// ----------------------------------------------------------------------------
// mjdc_date
// Date datapath: day number to year, month and day in nine register stages.
// ----------------------------------------------------------------------------
module mjdc_date (
    input  logic                             aclk,
    input  logic [mjdc_pkg::NSTAGE-1:0]      en,
    input  logic signed [22:0]               mjd_day,
    output mjdc_pkg::date_t                  date
);
    import mjdc_pkg::*;

    // stage 1: Julian Day, calendar select, alpha numerator
    logic signed [23:0] s1_z_next, s1_z_reg;
    logic               s1_greg_next, s1_greg_reg;
    logic [25:0]        s1_na_full;
    logic [24:0]        s1_na_reg;
    // stage 2: alpha estimate
    logic signed [23:0] s2_z_reg;
    logic               s2_greg_reg;
    logic [24:0]        s2_na_reg;
    logic [32:0]        s2_prod;
    logic [7:0]         s2_q_reg;
    // stage 3: alpha correction
    logic signed [23:0] s3_z_reg;
    logic               s3_greg_reg;
    logic [24:0]        s3_qd, s3_rem;
    logic [7:0]         s3_alpha_next, s3_alpha_reg;
    // stage 4: b and the offset c numerator
    logic [7:0]         s4_adj;
    logic signed [23:0] s4_b_next, s4_b_reg;
    logic signed [29:0] s4_nc;
    logic [27:0]        s4_nc_reg;
    // stage 5: c estimate
    logic signed [23:0] s5_b_reg;
    logic [27:0]        s5_nc_reg;
    logic [43:0]        s5_prod;
    logic [14:0]        s5_q_reg;
    // stage 6: c correction
    logic signed [23:0] s6_b_reg;
    logic [27:0]        s6_qd, s6_rem;
    logic [15:0]        s6_q;
    logic signed [15:0] s6_c_reg;
    // stage 7: days into the shifted year
    logic signed [26:0] s7_d;
    logic signed [27:0] s7_bd_full;
    logic [8:0]         s7_bd_reg;
    logic signed [15:0] s7_c_reg;
    // stage 8: month index search
    logic [3:0]         s8_e_next, s8_e_reg;
    logic [8:0]         s8_bd_reg;
    logic signed [15:0] s8_c_reg;
    // stage 9: output
    logic [3:0]         s9_month;
    logic signed [15:0] s9_year;
    date_t              s9_date_next, s9_date_reg;

    // Form the Julian Day and pick the calendar
    always_comb begin
        s1_z_next    = 24'(mjd_day) + JD_OFFSET;
        s1_greg_next = (s1_z_next >= JD_GREG);
        s1_na_full   = {s1_z_next, 2'b00} - ALPHA_BIAS;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            s1_z_reg    <= s1_z_next;
            s1_greg_reg <= s1_greg_next;
            s1_na_reg   <= s1_na_full[24:0];
        end
    end

    // Estimate alpha by reciprocal multiply; may read one low
    assign s2_prod = s1_na_reg * ALPHA_RECIP;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            s2_z_reg    <= s1_z_reg;
            s2_greg_reg <= s1_greg_reg;
            s2_na_reg   <= s1_na_reg;
            s2_q_reg    <= s2_prod[32:25];
        end
    end

    // Correct alpha by one where the remainder reaches the divisor
    always_comb begin
        s3_qd         = 25'(s2_q_reg) * ALPHA_DIV;
        s3_rem        = s2_na_reg - s3_qd;
        s3_alpha_next = (s3_rem >= ALPHA_DIV) ? s2_q_reg + 8'd1 : s2_q_reg;
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            s3_z_reg     <= s2_z_reg;
            s3_greg_reg  <= s2_greg_reg;
            s3_alpha_reg <= s3_alpha_next;
        end
    end

    // Apply the Gregorian correction, form b and the c numerator
    always_comb begin
        s4_adj    = s3_greg_reg ? (8'd1 + s3_alpha_reg - {2'b00, s3_alpha_reg[7:2]}) : 8'd0;
        s4_b_next = s3_z_reg + 24'(signed'({1'b0, s4_adj})) + 24'sd1524;
        s4_nc     = 30'(s4_b_next) * 30'sd20 + C_BIAS;
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            s4_b_reg  <= s4_b_next;
            s4_nc_reg <= s4_nc[27:0];
        end
    end

    // Estimate c by reciprocal multiply
    assign s5_prod = s4_nc_reg * C_RECIP;

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            s5_b_reg  <= s4_b_reg;
            s5_nc_reg <= s4_nc_reg;
            s5_q_reg  <= s5_prod[42:28];
        end
    end

    // Correct c and remove the positive offset
    always_comb begin
        s6_qd  = 28'(s5_q_reg) * C_DIV;
        s6_rem = s5_nc_reg - s6_qd;
        s6_q   = (s6_rem >= C_DIV) ? {1'b0, s5_q_reg} + 16'd1 : {1'b0, s5_q_reg};
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            s6_b_reg <= s5_b_reg;
            s6_c_reg <= signed'(s6_q - C_SHIFT);
        end
    end

    // Subtract the whole days of the completed years
    always_comb begin
        s7_d       = (27'(s6_c_reg) * 27'sd1461) >>> 2;
        s7_bd_full = 28'(s6_b_reg) - 28'(s7_d);
    end

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            s7_bd_reg <= s7_bd_full[8:0];
            s7_c_reg  <= s6_c_reg;
        end
    end

    // Find the last month start that lies strictly below the day count
    always_comb begin
        s8_e_next = 4'd4;
        for (int k = 5; k < 16; k++) begin
            if (s7_bd_reg > month_start(4'(k))) begin
                s8_e_next = 4'(k);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[7]) begin
            s8_e_reg  <= s8_e_next;
            s8_bd_reg <= s7_bd_reg;
            s8_c_reg  <= s7_c_reg;
        end
    end

    // Map to calendar month, day and year
    always_comb begin
        s9_month = (s8_e_reg < 4'd14) ? s8_e_reg - 4'd1 : s8_e_reg - 4'd13;
        s9_year  = (s8_e_reg < 4'd14) ? s8_c_reg - YEAR_OFS_LATE
                                      : s8_c_reg - YEAR_OFS_EARLY;
        s9_date_next.year         = s9_year[14:0];
        s9_date_next.month        = s9_month;
        s9_date_next.day_of_month = 5'(s8_bd_reg - month_start(s8_e_reg));
    end

    always_ff @(posedge aclk) begin
        if (en[8]) begin
            s9_date_reg <= s9_date_next;
        end
    end

    assign date = s9_date_reg;

endmodule

/* rtl/mjdc_tod.sv */
// ----------------------------------------------------------------------------
// mjdc_tod
// Time-of-day datapath: milliseconds to hour, minute, second, millisecond.
// ----------------------------------------------------------------------------
module mjdc_tod (
    input  logic                             aclk,
    input  logic [mjdc_pkg::NSTAGE-1:0]      en,
    input  logic [26:0]                      day_fraction_ms,
    output mjdc_pkg::tod_t                   tod
);
    import mjdc_pkg::*;

    logic [26:0] s1_ms_reg;
    logic [32:0] s2_prod;
    logic [26:0] s2_ms_reg;
    logic [4:0]  s2_q_reg;
    logic [26:0] s3_qd, s3_rem;
    logic [4:0]  s3_hour_reg;
    logic [21:0] s3_rem_reg;
    logic [28:0] s4_prod;
    logic [4:0]  s4_hour_reg;
    logic [21:0] s4_rem_reg;
    logic [5:0]  s4_q_reg;
    logic [21:0] s5_qd, s5_rem;
    logic [4:0]  s5_hour_reg;
    logic [5:0]  s5_min_reg;
    logic [15:0] s5_rem_reg;
    logic [22:0] s6_prod;
    logic [4:0]  s6_hour_reg;
    logic [5:0]  s6_min_reg;
    logic [15:0] s6_rem_reg;
    logic [5:0]  s6_q_reg;
    logic [15:0] s7_qd, s7_rem;
    tod_t        s7_tod_next, s7_tod_reg, s8_tod_reg, s9_tod_reg;

    // Clamp the time to the last millisecond of the day
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            s1_ms_reg <= (day_fraction_ms > MS_DAY_MAX) ? MS_DAY_MAX : day_fraction_ms;
        end
    end

    // Estimate the hour
    assign s2_prod = s1_ms_reg * HOUR_RECIP;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            s2_ms_reg <= s1_ms_reg;
            s2_q_reg  <= s2_prod[31:27];
        end
    end

    // Correct the hour and keep the remainder
    always_comb begin
        s3_qd  = 27'(s2_q_reg) * MS_HOUR;
        s3_rem = s2_ms_reg - s3_qd;
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            if (s3_rem >= MS_HOUR) begin
                s3_hour_reg <= s2_q_reg + 5'd1;
                s3_rem_reg  <= 22'(s3_rem - MS_HOUR);
            end else begin
                s3_hour_reg <= s2_q_reg;
                s3_rem_reg  <= s3_rem[21:0];
            end
        end
    end

    // Estimate the minute
    assign s4_prod = s3_rem_reg * MIN_RECIP;

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            s4_hour_reg <= s3_hour_reg;
            s4_rem_reg  <= s3_rem_reg;
            s4_q_reg    <= s4_prod[27:22];
        end
    end

    // Correct the minute and keep the remainder
    always_comb begin
        s5_qd  = 22'(s4_q_reg) * MS_MINUTE;
        s5_rem = s4_rem_reg - s5_qd;
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            s5_hour_reg <= s4_hour_reg;
            if (s5_rem >= MS_MINUTE) begin
                s5_min_reg <= s4_q_reg + 6'd1;
                s5_rem_reg <= 16'(s5_rem - MS_MINUTE);
            end else begin
                s5_min_reg <= s4_q_reg;
                s5_rem_reg <= s5_rem[15:0];
            end
        end
    end

    // Estimate the second
    assign s6_prod = s5_rem_reg * SEC_RECIP;

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            s6_hour_reg <= s5_hour_reg;
            s6_min_reg  <= s5_min_reg;
            s6_rem_reg  <= s5_rem_reg;
            s6_q_reg    <= s6_prod[21:16];
        end
    end

    // Correct the second; the remainder is the millisecond
    always_comb begin
        s7_qd  = 16'(s6_q_reg) * MS_SECOND;
        s7_rem = s6_rem_reg - s7_qd;
        s7_tod_next.hour   = s6_hour_reg;
        s7_tod_next.minute = s6_min_reg;
        if (s7_rem >= MS_SECOND) begin
            s7_tod_next.second      = s6_q_reg + 6'd1;
            s7_tod_next.millisecond = 10'(s7_rem - MS_SECOND);
        end else begin
            s7_tod_next.second      = s6_q_reg;
            s7_tod_next.millisecond = s7_rem[9:0];
        end
    end

    // Delay to line up with the date path
    always_ff @(posedge aclk) begin
        if (en[6]) begin
            s7_tod_reg <= s7_tod_next;
        end
        if (en[7]) begin
            s8_tod_reg <= s7_tod_reg;
        end
        if (en[8]) begin
            s9_tod_reg <= s8_tod_reg;
        end
    end

    assign tod = s9_tod_reg;

endmodule

/* rtl/mjd_to_calendar_date.sv */
// ----------------------------------------------------------------------------
// mjd_to_calendar_date
// Modified Julian Date plus milliseconds of day to calendar date and time.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Payload (tdata, low bit first)
//  s_       | in        | mjd_day[22:0], day_fraction_ms[49:23], zero pad to 56
//  m_       | out       | year[14:0], month[18:15], day_of_month[23:19],
//           |           | hour[28:24], minute[34:29], second[40:35],
//           |           | millisecond[50:41], zero pad to 56
//
//  One item per cycle enters when the output side takes one per cycle. The
//  depth is set by the two reciprocal divisions of the date path (estimate and
//  correction stage each) plus the month search.
//  Each stage has its own valid bit and takes new data when it is empty or
//  its successor moves, so bubbles close up under a stall and nothing is lost.
//  Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module mjd_to_calendar_date (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // mjd_day, day_fraction_ms
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // year, month, day_of_month, hour, minute,
                                   // second, millisecond
);
    import mjdc_pkg::*;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] en;
    date_t             date;
    tod_t              tod;

    // Stage enables: a stage moves when empty or when the next one moves
    always_comb begin
        en[NSTAGE-1] = !valid_reg[NSTAGE-1] || m_tready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    // Advance the valid bits with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (en[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    mjdc_date u_date (
        .aclk    (aclk),
        .en      (en),
        .mjd_day (signed'(s_tdata[22:0])),
        .date    (date)
    );

    mjdc_tod u_tod (
        .aclk            (aclk),
        .en              (en),
        .day_fraction_ms (s_tdata[49:23]),
        .tod             (tod)
    );

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[NSTAGE-1];
    assign m_tdata  = {5'd0, tod.millisecond, tod.second, tod.minute, tod.hour,
                       date.day_of_month, date.month, date.year};

endmodule

/* rtl/mjdc_checker.sv */
// ----------------------------------------------------------------------------
// mjdc_checker
// Port-level checks for the MJD to calendar date converter.
// ----------------------------------------------------------------------------
module mjdc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    // Hold a stalled result item
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed under stall");

    // Drop all items on reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // An empty output stage lets the whole pipeline move
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // Date fields stay in calendar range
    a_date_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[18:15] >= 4'd1 && m_tdata[18:15] <= 4'd12 &&
                     m_tdata[23:19] >= 5'd1 && m_tdata[23:19] <= 5'd31)
        else $error("month or day out of range");

    // Time fields stay in clock range
    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[28:24] <= 5'd23 && m_tdata[34:29] <= 6'd59 &&
                     m_tdata[40:35] <= 6'd59 && m_tdata[50:41] <= 10'd999)
        else $error("time of day out of range");

endmodule

bind mjd_to_calendar_date mjdc_checker u_mjdc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
